// ===== src/acir_pkg.sv =====
// shared types, timing constants and frame builder for the ir frame timing encoder
package acir_pkg;

    // frame layout
    localparam int NUM_BYTES     = 18;
    localparam int FRAME_BITS    = NUM_BYTES * 8;
    localparam int FRAME_ENTRIES = 2 + FRAME_BITS * 2 + 2;
    localparam int K_W           = $clog2(FRAME_ENTRIES);
    localparam int BIT_W         = $clog2(FRAME_BITS);
    localparam int DEF_REPEATS   = 2;

    // durations in microseconds
    localparam int DUR_W = 14;
    localparam logic [DUR_W-1:0] T_HDR_MARK   = 14'd3400;
    localparam logic [DUR_W-1:0] T_HDR_SPACE  = 14'd1750;
    localparam logic [DUR_W-1:0] T_BIT_MARK   = 14'd450;
    localparam logic [DUR_W-1:0] T_ONE_SPACE  = 14'd1300;
    localparam logic [DUR_W-1:0] T_ZERO_SPACE = 14'd420;
    localparam logic [DUR_W-1:0] T_FTR_MARK   = 14'd440;
    localparam logic [DUR_W-1:0] T_FTR_SPACE  = 14'd15500;

    // fixed signature bytes
    localparam logic [7:0] SIG_B0  = 8'h23;
    localparam logic [7:0] SIG_B1  = 8'hCB;
    localparam logic [7:0] SIG_B2  = 8'h26;
    localparam logic [7:0] SIG_B3  = 8'h01;
    localparam logic [7:0] SIG_B4  = 8'h00;
    localparam logic [7:0] SIG_B10 = 8'h67;
    localparam logic [7:0] SIG_SUM = 8'(SIG_B0 + SIG_B1 + SIG_B2 + SIG_B3 + SIG_B4 + SIG_B10);

    // per-mode extra byte values
    localparam logic [7:0] EXTRA_AUTO = 8'h30;
    localparam logic [7:0] EXTRA_COOL = 8'h36;
    localparam logic [7:0] EXTRA_DRY  = 8'h32;
    localparam logic [7:0] EXTRA_FAN  = 8'h37;

    // temperature limits
    localparam logic [5:0] TEMP_MIN = 6'd16;
    localparam logic [5:0] TEMP_MAX = 6'd31;

    // operating modes
    typedef enum logic [2:0] {
        MODE_AUTO = 3'd0,
        MODE_COOL = 3'd1,
        MODE_DRY  = 3'd2,
        MODE_HEAT = 3'd3,
        MODE_FAN  = 3'd4
    } hvac_mode_t;

    // register indexes
    typedef enum logic [2:0] {
        REG_POWER = 3'd0,
        REG_MODE  = 3'd1,
        REG_TEMP  = 3'd2,
        REG_FAN   = 3'd3,
        REG_SWING = 3'd4
    } reg_idx_t;

    localparam int ADDR_W = 5;

    typedef struct packed {
        logic       power_on;
        logic [2:0] hvac_mode;
        logic [5:0] set_temp_c;
        logic [1:0] fan_speed;
        logic       swing_on;
    } cfg_t;

    typedef enum logic [2:0] {
        KIND_HDR_MARK  = 3'd0,
        KIND_HDR_SPACE = 3'd1,
        KIND_BIT_MARK  = 3'd2,
        KIND_BIT_SPACE = 3'd3,
        KIND_FTR_MARK  = 3'd4,
        KIND_FTR_SPACE = 3'd5
    } entry_kind_t;

    // one classified entry on its way from front to back
    typedef struct packed {
        entry_kind_t      kind;
        logic [BIT_W-1:0] bit_idx;
        logic             last;
    } entry_t;

    function automatic logic [2:0] mode_code(input logic [2:0] mode);
        logic [2:0] code;
        code = 3'd4;
        unique case (mode)
            MODE_COOL: code = 3'd3;
            MODE_DRY:  code = 3'd2;
            MODE_HEAT: code = 3'd1;
            MODE_FAN:  code = 3'd7;
            default:   code = 3'd4;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] mode_extra(input logic [2:0] mode);
        logic [7:0] extra;
        extra = EXTRA_AUTO;
        unique case (mode)
            MODE_COOL: extra = EXTRA_COOL;
            MODE_DRY:  extra = EXTRA_DRY;
            MODE_FAN:  extra = EXTRA_FAN;
            default:   extra = EXTRA_AUTO;
        endcase
        return extra;
    endfunction

    // whole frame, byte i at bits [8i+7:8i] so bit n goes out n-th
    function automatic logic [FRAME_BITS-1:0] build_frame(input cfg_t cfg);
        logic [7:0] b5;
        logic [7:0] b6;
        logic [7:0] b7;
        logic [7:0] b8;
        logic [7:0] b9;
        logic [7:0] sum;
        logic [3:0] t4;
        if (cfg.set_temp_c < TEMP_MIN) begin
            t4 = 4'd0;
        end else if (cfg.set_temp_c > TEMP_MAX) begin
            t4 = 4'd15;
        end else begin
            t4 = 4'(cfg.set_temp_c - TEMP_MIN);
        end
        b5  = {2'b00, cfg.power_on, 5'b00000};
        b6  = {2'b00, mode_code(cfg.hvac_mode), 3'b000};
        b7  = {4'b0000, t4};
        b8  = mode_extra(cfg.hvac_mode);
        b9  = {(cfg.fan_speed == 2'd0), 1'b0, {3{cfg.swing_on}}, 1'b0, cfg.fan_speed};
        sum = 8'(SIG_SUM + b5 + b6 + b7 + b8 + b9);
        return {sum, 48'h0, SIG_B10, b9, b8, b7, b6, b5,
                SIG_B4, SIG_B3, SIG_B2, SIG_B1, SIG_B0};
    endfunction

endpackage

// ===== src/acir_front.sv =====
// front end: takes pull beats, tracks the entry position and classifies each entry
module acir_front
    import acir_pkg::*;
#(
    parameter int FRAME_REPEATS = DEF_REPEATS
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  logic   restart,
    input  logic   q_full,
    output logic   q_push,
    output entry_t q_entry
);

    localparam int REP_W = (FRAME_REPEATS > 1) ? $clog2(FRAME_REPEATS) : 1;
    localparam logic [K_W-1:0]   K_LAST   = K_W'(FRAME_ENTRIES - 1);
    localparam logic [K_W-1:0]   K_FTR_MK = K_W'(FRAME_ENTRIES - 2);
    localparam logic [REP_W-1:0] REP_LAST = REP_W'(FRAME_REPEATS - 1);

    logic [K_W-1:0]   k_reg;
    logic [K_W-1:0]   k_next;
    logic [REP_W-1:0] rep_reg;
    logic [REP_W-1:0] rep_next;
    logic [K_W-1:0]   cur_k;
    logic [REP_W-1:0] cur_rep;
    logic [K_W-1:0]   k_off;
    logic             cur_last;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // position used for this beat, restart taking effect first
    assign cur_k    = restart ? '0 : k_reg;
    assign cur_rep  = restart ? '0 : rep_reg;
    assign cur_last = (cur_k == K_LAST) && (cur_rep == REP_LAST);
    assign k_off    = cur_k - K_W'(2);

    // classify the entry
    always_comb
    begin
        q_entry.bit_idx = k_off[BIT_W:1];
        q_entry.last    = cur_last;
        priority if (cur_k == '0)
        begin
            q_entry.kind = KIND_HDR_MARK;
        end
        else if (cur_k == K_W'(1))
        begin
            q_entry.kind = KIND_HDR_SPACE;
        end
        else if (cur_k == K_FTR_MK)
        begin
            q_entry.kind = KIND_FTR_MARK;
        end
        else if (cur_k == K_LAST)
        begin
            q_entry.kind = KIND_FTR_SPACE;
        end
        else if (!cur_k[0])
        begin
            q_entry.kind = KIND_BIT_MARK;
        end
        else
        begin
            q_entry.kind = KIND_BIT_SPACE;
        end
    end

    // advance the position, wrapping after the last entry
    always_comb
    begin
        k_next   = k_reg;
        rep_next = rep_reg;
        if (q_push)
        begin
            if (cur_k == K_LAST)
            begin
                k_next   = '0;
                rep_next = cur_last ? '0 : REP_W'(cur_rep + 1'b1);
            end
            else
            begin
                k_next   = K_W'(cur_k + 1'b1);
                rep_next = cur_rep;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= '0;
            rep_reg <= '0;
        end
        else
        begin
            k_reg   <= k_next;
            rep_reg <= rep_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n) k_reg <= K_LAST)
        else $error("entry position past end of frame");
    a_rep_range: assert property (@(posedge clk) disable iff (!rst_n) rep_reg <= REP_LAST)
        else $error("repeat count past last frame");
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_entry.last) |=> (k_reg == '0 && rep_reg == '0))
        else $error("position did not wrap after last entry");
`endif

endmodule

// ===== src/acir_queue.sv =====
// two-entry queue between the classifying front and the timing back end
module acir_queue
    import acir_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head
);

    localparam int DEPTH = 2;

    entry_t     slot_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'(DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = 2'(count_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'(DEPTH))
        else $error("queue overfilled");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("pop from empty queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == 2'($past(count_reg) + $past(push) - $past(pop))))
        else $error("queue count out of step with push and pop");
`endif

endmodule

// ===== src/acir_back.sv =====
// back end: turns classified entries into durations and holds the result beat
module acir_back
    import acir_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             head_valid,
    input  entry_t           head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [DUR_W-1:0] duration_us,
    output logic             is_mark,
    output logic             last
);

    logic [FRAME_BITS-1:0] frame;
    logic [DUR_W-1:0]      dur;
    logic                  mark;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DUR_W-1:0]      duration_reg;
    logic                  is_mark_reg;
    logic                  last_reg;

    assign frame = build_frame(cfg);

    // duration lookup
    always_comb
    begin
        unique case (head.kind)
            KIND_HDR_MARK:  begin dur = T_HDR_MARK;  mark = 1'b1; end
            KIND_HDR_SPACE: begin dur = T_HDR_SPACE; mark = 1'b0; end
            KIND_BIT_MARK:  begin dur = T_BIT_MARK;  mark = 1'b1; end
            KIND_BIT_SPACE:
            begin
                dur  = frame[head.bit_idx] ? T_ONE_SPACE : T_ZERO_SPACE;
                mark = 1'b0;
            end
            KIND_FTR_MARK:  begin dur = T_FTR_MARK;  mark = 1'b1; end
            KIND_FTR_SPACE: begin dur = T_FTR_SPACE; mark = 1'b0; end
            default:        begin dur = T_FTR_SPACE; mark = 1'b0; end
        endcase
    end

    // load the output register when it is empty or being taken
    assign pop            = head_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = pop || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            duration_reg <= dur;
            is_mark_reg  <= mark;
            last_reg     <= head.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign duration_us = duration_reg;
    assign is_mark     = is_mark_reg;
    assign last        = last_reg;

endmodule

// ===== src/ac_ir_frame_timing_encoder_top.sv =====
// top level of the ir frame timing encoder: config registers, front, queue and back end
// an accepted pull is classified, stored in the queue, then popped into the output register
// throughput: one entry per cycle while out_stall is low; a stalled output holds the queue
// a transmission is 292 entries per frame times FRAME_REPEATS, then wraps to the first entry
// reset: position to first entry, queue and output empty, settings off/auto/24 C/auto/fixed
module ac_ir_frame_timing_encoder_top
    import acir_pkg::*;
#(
    parameter int FRAME_REPEATS = DEF_REPEATS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              restart,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DUR_W-1:0]  duration_us,
    output logic              is_mark,
    output logic              last
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_head_valid;
    entry_t   q_in;
    entry_t   q_head;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_POWER: cfg_next.power_on   = pwdata[0];
                REG_MODE:  cfg_next.hvac_mode  = pwdata[2:0];
                REG_TEMP:  cfg_next.set_temp_c = pwdata[5:0];
                REG_FAN:   cfg_next.fan_speed  = pwdata[1:0];
                REG_SWING: cfg_next.swing_on   = pwdata[0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_on   <= 1'b0;
            cfg_reg.hvac_mode  <= MODE_AUTO;
            cfg_reg.set_temp_c <= 6'd24;
            cfg_reg.fan_speed  <= 2'd0;
            cfg_reg.swing_on   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_idx)
            REG_POWER: prdata = {31'd0, cfg_reg.power_on};
            REG_MODE:  prdata = {29'd0, cfg_reg.hvac_mode};
            REG_TEMP:  prdata = {26'd0, cfg_reg.set_temp_c};
            REG_FAN:   prdata = {30'd0, cfg_reg.fan_speed};
            REG_SWING: prdata = {31'd0, cfg_reg.swing_on};
            default:   prdata = 32'd0;
        endcase
    end

    acir_front #(
        .FRAME_REPEATS (FRAME_REPEATS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .restart  (restart),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    acir_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    acir_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_valid  (q_head_valid),
        .head        (q_head),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duration_us (duration_us),
        .is_mark     (is_mark),
        .last        (last)
    );

endmodule

// ===== test/tb.sv =====
// testbench for the ir frame timing encoder: randomized pulls checked against a timing predictor
`timescale 1ns / 100ps

module tb;
    import acir_pkg::*;

    localparam int TX_ENTRIES   = FRAME_ENTRIES * DEF_REPEATS;
    localparam int NUM_PHASES   = 13;
    localparam int PHASE_PULLS  = 30;
    localparam int STEADY_PHASE = 6;     // restart on its first pull only, then none, so the position runs on
    localparam int HOLD_PHASE   = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_GAP   = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 40;

    // register slot past the end of the map, writes there must be ignored
    localparam int REG_SPARE = 5;

    // hvac_mode values with no meaning of their own
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // mode codes carried in byte 6
    localparam logic [2:0] CODE_AUTO = 3'd4;
    localparam logic [2:0] CODE_COOL = 3'd3;
    localparam logic [2:0] CODE_DRY  = 3'd2;
    localparam logic [2:0] CODE_HEAT = 3'd1;
    localparam logic [2:0] CODE_FAN  = 3'd7;

    // one timing entry as the block should emit it
    typedef struct {
        logic [DUR_W-1:0] dur;
        logic             mark;
        logic             fin;
    } pulse_exp_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              restart = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DUR_W-1:0]  duration_us;
    logic              is_mark;
    logic              last;

    // stimulus and prediction state
    logic       pull_q[$];
    pulse_exp_t pending_pulses[$];
    cfg_t       cfg_now;
    int         tx_pos = 0;
    logic       pull_taken = 1'b0;
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    logic       hold_armed = 1'b0;
    logic       hold_taken = 1'b0;
    int         hold_left = 0;

    // bookkeeping
    int err_count = 0;
    int pulls_done = 0;
    int beats_seen = 0;
    int restarts_sent = 0;
    int ends_seen = 0;
    int settings_used = 0;
    int cycle_count = 0;

    ac_ir_frame_timing_encoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duration_us (duration_us),
        .is_mark     (is_mark),
        .last        (last)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // 18-byte command frame, bit n of the result goes out n-th
    function automatic logic [FRAME_BITS-1:0] frame_image(input cfg_t c);
        logic [7:0]            fb [NUM_BYTES];
        logic [7:0]            csum;
        logic [2:0]            code;
        logic [7:0]            extra;
        logic [5:0]            tc;
        logic [FRAME_BITS-1:0] img;
        int                    i;
        for (i = 0; i < NUM_BYTES; i++)
            fb[i] = 8'h00;
        unique case (c.hvac_mode)
            MODE_COOL:
            begin
                code  = CODE_COOL;
                extra = EXTRA_COOL;
            end
            MODE_DRY:
            begin
                code  = CODE_DRY;
                extra = EXTRA_DRY;
            end
            MODE_HEAT:
            begin
                code  = CODE_HEAT;
                extra = EXTRA_AUTO;
            end
            MODE_FAN:
            begin
                code  = CODE_FAN;
                extra = EXTRA_FAN;
            end
            default:
            begin
                code  = CODE_AUTO;
                extra = EXTRA_AUTO;
            end
        endcase
        // clamp temperature into the encodable window
        if (c.set_temp_c < TEMP_MIN)
            tc = TEMP_MIN;
        else if (c.set_temp_c > TEMP_MAX)
            tc = TEMP_MAX;
        else
            tc = c.set_temp_c;
        fb[0]  = SIG_B0;
        fb[1]  = SIG_B1;
        fb[2]  = SIG_B2;
        fb[3]  = SIG_B3;
        fb[4]  = SIG_B4;
        fb[5]  = {2'b00, c.power_on, 5'b00000};
        fb[6]  = {2'b00, code, 3'b000};
        fb[7]  = 8'(tc - TEMP_MIN);
        fb[8]  = extra;
        fb[9]  = {c.fan_speed == 2'd0, 1'b0, c.swing_on ? 3'b111 : 3'b000, 1'b0, c.fan_speed};
        fb[10] = SIG_B10;
        // checksum over bytes 0..16
        csum = 8'h00;
        for (i = 0; i < NUM_BYTES - 1; i++)
            csum = csum + fb[i];
        fb[NUM_BYTES-1] = csum;
        for (i = 0; i < NUM_BYTES; i++)
            img[8*i +: 8] = fb[i];
        return img;
    endfunction

    // next timing entry of the transmission, advances the position
    function automatic pulse_exp_t next_pulse(input logic rs);
        pulse_exp_t            p;
        int                    k;
        int                    b;
        logic [FRAME_BITS-1:0] img;
        if (rs || tx_pos >= TX_ENTRIES)
            tx_pos = 0;
        k = tx_pos % FRAME_ENTRIES;
        p.mark = (k % 2 == 0);
        if (k == 0)
            p.dur = T_HDR_MARK;
        else if (k == 1)
            p.dur = T_HDR_SPACE;
        else if (k == FRAME_ENTRIES - 2)
            p.dur = T_FTR_MARK;
        else if (k == FRAME_ENTRIES - 1)
            p.dur = T_FTR_SPACE;
        else if (p.mark)
            p.dur = T_BIT_MARK;
        else
        begin
            b   = (k - 2) / 2;
            img = frame_image(cfg_now);
            p.dur = img[b] ? T_ONE_SPACE : T_ZERO_SPACE;
        end
        p.fin  = (tx_pos == TX_ENTRIES - 1);
        tx_pos = (tx_pos + 1 >= TX_ENTRIES) ? 0 : tx_pos + 1;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_REPORTS)
            $display("mismatch: %s at beat %0d, got %0d, want %0d", what, beats_seen, got, want);
        err_count++;
    endtask

    // apb write: setup cycle, then access until pready
    task automatic write_reg(input int idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // field value with random junk above it, which the block must drop
    function automatic logic [31:0] padded(input logic [5:0] v, input int w);
        return (32'($urandom) << w) | 32'(v);
    endfunction

    task automatic apply_settings(input cfg_t c);
        write_reg(REG_POWER, padded(6'(c.power_on), 1));
        write_reg(REG_MODE, padded(6'(c.hvac_mode), 3));
        write_reg(REG_TEMP, padded(c.set_temp_c, 6));
        write_reg(REG_FAN, padded(6'(c.fan_speed), 2));
        write_reg(REG_SWING, padded(6'(c.swing_on), 1));
        cfg_now = c;
        settings_used++;
    endtask

    // extremes first, then random settings
    function automatic cfg_t phase_settings(input int ph);
        cfg_t c;
        unique case (ph)
            0: c = {1'b0, MODE_AUTO, 6'd0, 2'd0, 1'b0};
            1: c = {1'b1, MODE_COOL, 6'd15, 2'd1, 1'b1};
            2: c = {1'b1, MODE_DRY, 6'd16, 2'd2, 1'b0};
            3: c = {1'b0, MODE_HEAT, 6'd31, 2'd3, 1'b1};
            4: c = {1'b1, MODE_FAN, 6'd32, 2'd0, 1'b1};
            5: c = {1'b1, MODE_SPARE_HI, 6'd63, 2'd3, 1'b0};
            6: c = {1'b0, MODE_SPARE_LO, 6'd24, 2'd2, 1'b1};
            default: c = 13'($urandom);
        endcase
        return c;
    endfunction

    // wait for the block to go quiet
    task automatic drain();
        while (pull_q.size() != 0 || in_valid || pending_pulses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // pull driver
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !pull_taken))
        begin
            if (pull_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                in_valid <= 1'b1;
                restart  <= pull_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_armed && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // monitor: predict on each accepted pull, check each accepted result beat
    always @(posedge clk)
    begin
        pulse_exp_t want;
        pull_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            pending_pulses.push_back(next_pulse(restart));
            pulls_done++;
            if (restart)
                restarts_sent++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pulses.size() == 0)
                report_mismatch("beat with nothing pending", duration_us, 0);
            else
            begin
                want = pending_pulses.pop_front();
                if (duration_us !== want.dur)
                    report_mismatch("duration_us", duration_us, want.dur);
                if (is_mark !== want.mark)
                    report_mismatch("is_mark", is_mark, want.mark);
                if (last !== want.fin)
                    report_mismatch("last", last, want.fin);
                if (last === 1'b1)
                    ends_seen++;
            end
            beats_seen++;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL ac_ir_frame_timing_encoder_top");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        int ph;
        int i;
        cfg_now = {1'b0, MODE_AUTO, 6'd24, 2'd0, 1'b0};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, header entries and two restarts mid-frame
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        for (i = 0; i < 24; i++)
            pull_q.push_back(i == 3 || i == 20);
        drain();

        // ignored slot past the register map
        write_reg(REG_SPARE, $urandom);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            apply_settings(phase_settings(ph));
            unique case (ph % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 81;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 81;
                end
                default:
                begin
                    tx_idle_pct  = 26;
                    rx_stall_pct = 26;
                end
            endcase
            // restarts early on, then one long unbroken run across settings changes
            for (i = 0; i < PHASE_PULLS; i++)
            begin
                if (ph < STEADY_PHASE)
                    pull_q.push_back($urandom_range(0, 99) == 0);
                else
                    pull_q.push_back(ph == STEADY_PHASE && i == 0);
            end
            if (ph == HOLD_PHASE)
                hold_armed = 1'b1;
            drain();
        end

        $display("pulled %0d entries (%0d with restart), %0d end-of-transmission beats",
                 pulls_done, restarts_sent, ends_seen);
        $display("%0d register settings applied, %0d beats checked", settings_used, beats_seen);
        if (err_count == 0)
        begin
            $display("PASS ac_ir_frame_timing_encoder_top");
        end
        else
        begin
            $display("FAIL ac_ir_frame_timing_encoder_top");
        end
        $finish;
    end

endmodule

// ===== ac_ir_frame_timing_encoder_top.f =====
src/acir_pkg.sv
src/acir_front.sv
src/acir_queue.sv
src/acir_back.sv
src/ac_ir_frame_timing_encoder_top.sv
test/tb.sv
